>>> rtl/ics_pkg.sv
// Shared types, constants and helpers for the streaming Internet checksum core.
// No dependencies; imported by every module under rtl/.
`timescale 1ns / 1ps

package ics_pkg;

    // Segment length limit and the width of the word counter it implies
    localparam int MaxWords = 32768;
    localparam int PosW     = $clog2(MaxWords);

    localparam logic [PosW-1:0] PosLast = PosW'(MaxWords - 1);

    // Register file layout: one 32-bit register per 4-byte slot
    localparam int AddrW = 3;
    localparam int DataW = 32;

    typedef enum logic {
        REG_SKIP_ENABLE   = 1'b0,
        REG_SKIP_POSITION = 1'b1
    } t_reg_idx;

    localparam logic       SkipEnableRst   = 1'b1;
    localparam logic [5:0] SkipPositionRst = 6'd8;

    localparam logic [15:0] SumZero  = 16'h0000;
    localparam logic [15:0] SumOnes  = 16'hffff;
    localparam logic [15:0] TailMask = 16'hff00;

    // One input word with its framing flags
    typedef struct packed {
        logic [15:0] data_word;
        logic [15:0] seed_sum;
        logic        first_word;
        logic        last_word;
        logic        odd_tail;
    } t_in_word;

    // Live configuration
    typedef struct packed {
        logic       skip_enable;
        logic [5:0] skip_position;
    } t_cfg;

    // One result word
    typedef struct packed {
        logic [15:0] checksum;
        logic [15:0] folded_sum;
    } t_result;

    // 16-bit one's-complement add with end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        logic [16:0] f;
        s = {1'b0, a} + {1'b0, b};
        f = {1'b0, s[15:0]} + {16'd0, s[16]};
        return f[15:0];
    endfunction

endpackage

>>> rtl/ics_cfg_regs.sv
// APB-style register file holding skip_enable and skip_position.
// Depends on ics_pkg.
`timescale 1ns / 1ps

module ics_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ics_pkg::AddrW-1:0]  paddr,
    input  logic [ics_pkg::DataW-1:0]  pwdata,
    output logic [ics_pkg::DataW-1:0]  prdata,
    output logic                       pready,
    output ics_pkg::t_cfg              o_cfg
);
    import ics_pkg::*;

    logic       r_skip_enable;
    logic [5:0] r_skip_position;
    logic       wr_en;
    t_reg_idx   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    // Low address bits select byte lanes only
    assign reg_idx = t_reg_idx'(paddr[2]);

    // Write registers on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_enable   <= SkipEnableRst;
            r_skip_position <= SkipPositionRst;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SKIP_ENABLE:   r_skip_enable   <= pwdata[0];
                REG_SKIP_POSITION: r_skip_position <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            REG_SKIP_ENABLE:   prdata = {{(DataW-1){1'b0}}, r_skip_enable};
            REG_SKIP_POSITION: prdata = {{(DataW-6){1'b0}}, r_skip_position};
            default:           prdata = '0;
        endcase
    end

    assign o_cfg.skip_enable   = r_skip_enable;
    assign o_cfg.skip_position = r_skip_position;

endmodule

>>> rtl/ics_in_reg.sv
// Input register stage: captures one word and holds it until the adder takes it.
// Depends on ics_pkg.
`timescale 1ns / 1ps

module ics_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ics_pkg::t_in_word i_word,
    input  logic              i_take,
    output logic              o_valid,
    output ics_pkg::t_in_word o_word
);
    import ics_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    // Free slot, or the held word leaves this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Load payload on accept
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

>>> rtl/ics_accum.sv
// Running one's-complement sum and word counter; forms the result on the last word.
// Depends on ics_pkg.
`timescale 1ns / 1ps

module ics_accum (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  ics_pkg::t_in_word i_word,
    input  ics_pkg::t_cfg     i_cfg,
    output logic              o_res_valid,
    output ics_pkg::t_result  o_res
);
    import ics_pkg::*;

    logic [15:0]     r_sum;
    logic [PosW-1:0] r_pos;
    logic [15:0]     n_sum;
    logic [PosW-1:0] n_pos;

    logic [15:0]     base_sum;
    logic [PosW-1:0] base_pos;
    logic            odd;
    logic            skip;
    logic [15:0]     add_word;
    logic [15:0]     sum_out;
    logic [15:0]     chk;

    // Seed on the first word, else continue
    always_comb begin
        base_sum = i_word.first_word ? i_word.seed_sum : r_sum;
        base_pos = i_word.first_word ? '0 : r_pos;
        odd      = i_word.odd_tail & i_word.last_word;
        add_word = odd ? (i_word.data_word & TailMask) : i_word.data_word;
        // Padded tail byte is never the checksum field
        skip     = !odd && i_cfg.skip_enable
                   && (base_pos == {{(PosW-6){1'b0}}, i_cfg.skip_position});
        sum_out  = skip ? base_sum : ones_add(base_sum, add_word);
    end

    // Advance state; clear after the last word
    always_comb begin
        if (i_word.last_word) begin
            n_sum = SumZero;
            n_pos = '0;
        end else begin
            n_sum = sum_out;
            n_pos = (base_pos < PosLast) ? base_pos + PosW'(1) : base_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= SumZero;
            r_pos <= '0;
        end else if (i_take) begin
            r_sum <= n_sum;
            r_pos <= n_pos;
        end
    end

    // Complement, zero maps to all ones
    assign chk = ~sum_out;

    assign o_res_valid     = i_take & i_word.last_word;
    assign o_res.folded_sum = sum_out;
    assign o_res.checksum   = (chk == SumZero) ? SumOnes : chk;

endmodule

>>> rtl/ics_out_reg.sv
// Result register: holds one result word until the consumer takes it.
// Depends on ics_pkg.
`timescale 1ns / 1ps

module ics_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  ics_pkg::t_result i_res,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output ics_pkg::t_result o_res
);
    import ics_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Room if empty or the held word drains now
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

>>> rtl/internet_checksum_stream_core.sv
// Top level of the streaming RFC 1071 Internet checksum core.
// Depends on ics_pkg, ics_cfg_regs, ics_in_reg, ics_accum, ics_out_reg.
`timescale 1ns / 1ps

// Takes one 16-bit segment word per cycle (first byte in the upper half) and
// adds it with end-around carry into a running sum; the first word of a
// segment loads seed_sum, and the word at skip_position is left out while
// skip_enable is set, unless it is an odd tail. On a word flagged last, one
// result gives the folded sum and the checksum (its complement, 0x0000 sent
// as 0xFFFF); an odd tail keeps only the upper byte. A word is registered on
// entry and then summed; a last word's result is loaded into the result
// register. While ready is high the core sustains one word per cycle. Input
// ready drops only when a last word is held at the adder while the result
// register is full and not being taken. Write configuration only while idle.
module internet_checksum_stream_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Input word channel
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [15:0]                i_data_word,
    input  logic [15:0]                i_seed_sum,
    input  logic                       i_first_word,
    input  logic                       i_last_word,
    input  logic                       i_odd_tail,
    // Result channel
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [15:0]                o_checksum,
    output logic [15:0]                o_folded_sum,
    // Configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ics_pkg::AddrW-1:0]  paddr,
    input  logic [ics_pkg::DataW-1:0]  pwdata,
    output logic [ics_pkg::DataW-1:0]  prdata,
    output logic                       pready
);
    import ics_pkg::*;

    t_cfg     cfg;
    t_in_word in_word;
    t_in_word held_word;
    logic     held_valid;
    logic     take;
    logic     res_valid;
    t_result  res;
    t_result  out_res;
    logic     out_free;

    assign in_word.data_word  = i_data_word;
    assign in_word.seed_sum   = i_seed_sum;
    assign in_word.first_word = i_first_word;
    assign in_word.last_word  = i_last_word;
    assign in_word.odd_tail   = i_odd_tail;

    ics_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ics_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_word  (in_word),
        .i_take  (take),
        .o_valid (held_valid),
        .o_word  (held_word)
    );

    // Sum the held word unless it is a last word with nowhere to go
    assign take = held_valid && (!held_word.last_word || out_free);

    ics_accum u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_word      (held_word),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ics_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (out_res)
    );

    assign o_checksum   = out_res.checksum;
    assign o_folded_sum = out_res.folded_sum;

endmodule
